// File: hdl/gl3ns_pkg.sv
// Shared types and constants of the layer-3 network session sequencer.
`timescale 1ns / 1ps
`default_nettype none
package gl3ns_pkg;

  localparam int MaxMsgBytes   = 32;
  localparam int IdentityBytes = 8;
  localparam int AddrW         = $clog2(MaxMsgBytes);
  localparam int CntW          = $clog2(MaxMsgBytes + 2);
  localparam int IdW           = 8 * IdentityBytes;
  localparam int IdLenPos      = 9;
  localparam int IdOffset      = 10;
  localparam int IdMinLen      = IdOffset + IdentityBytes;

  localparam logic [3:0] PdCc  = 4'h3;
  localparam logic [3:0] PdMm  = 4'h5;
  localparam logic [3:0] PdRr  = 4'h6;
  localparam logic [3:0] PdSms = 4'h9;

  localparam logic [5:0] MtSetup      = 6'h05;
  localparam logic [5:0] MtLuReq      = 6'h08;
  localparam logic [5:0] MtCmReq      = 6'h24;
  localparam logic [5:0] MtPageResp   = 6'h27;
  localparam logic [5:0] MtCallConf   = 6'h08;
  localparam logic [5:0] MtAlerting   = 6'h01;
  localparam logic [5:0] MtConnect    = 6'h07;
  localparam logic [5:0] MtDisconnect = 6'h25;
  localparam logic [5:0] MtAssignDone = 6'h29;
  localparam logic [5:0] MtConnAck    = 6'h0f;
  localparam logic [5:0] MtRelCompl   = 6'h2a;
  localparam logic [5:0] MtCpData     = 6'h01;
  localparam logic [5:0] MtCpAck      = 6'h04;

  localparam logic [7:0] IeBearer = 8'h04;
  localparam logic [7:0] IeCalled = 8'h5e;
  localparam logic [3:0] RpHigh   = 4'h4;

  typedef enum logic [2:0] {
    ACT_EST, ACT_RCV, ACT_PAGE, ACT_CONT, ACT_ACK, ACT_BEGIN
  } act_e;

  typedef enum logic [4:0] {
    K_NONE, K_LU_ACCEPT, K_AUTH_REQ, K_AUTH_REJ, K_CHAN_REL, K_CM_ACCEPT,
    K_CALL_PROC, K_TRAFFIC, K_CALL_ALERT, K_CALL_CONN, K_CIPHER, K_MM_INFO,
    K_IN_SETUP, K_CONN_ACK, K_CALL_REL, K_SAPI3_EST, K_SMS_DATA, K_SMS_ACK,
    K_REL_COMPLETE
  } kind_e;

  typedef enum logic [4:0] {
    S_IDLE, S_PAGE_RESP, S_PAGE_CONT, S_CONT, S_CIPHER_ACK, S_CHREL_ACK,
    S_CMACC_ACK, S_AREQ_ACK, S_LUACC_ACK, S_OUT_SETUP, S_PROC_ACK, S_TRAFFIC,
    S_ALERT_ACK, S_OCONN_ACK, S_AUTH_RESP, S_AREJ_ACK, S_INSETUP_ACK, S_ACTIVE,
    S_MMINFO_ACK, S_SAPI3, S_CPDATA_ACK, S_SMS_RESP, S_CPACK_ACK, S_CONNACK_ACK,
    S_CREL_ACK, S_REL_COMPLETE, S_ASSIGN_DONE
  } sess_e;

  typedef enum logic [1:0] {SVC_NONE, SVC_CALL, SVC_SMS, SVC_SMART} svc_e;

  typedef enum logic [1:0] {IE_ID, IE_VL, IE_V0} ie_e;

  typedef enum logic [1:0] {C_IDLE, C_WALK, C_TAIL, C_EVAL} ctl_e;

  typedef enum logic {REG_AUTH_REQ, REG_PART_CNT} reg_e;

  typedef struct packed {
    logic             take;
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             eval;
  } cmd_t;

  typedef struct packed {
    logic             walk;
    logic             direct;
    logic [AddrW-1:0] last_addr;
    logic             out_free;
  } stat_t;

endpackage
`default_nettype wire

// File: hdl/gl3ns_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module gl3ns_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: hdl/gl3ns_ctrl.sv
// Sequencer: accepts words, walks the message buffer, triggers evaluation.
`timescale 1ns / 1ps
`default_nettype none
module gl3ns_ctrl
  import gl3ns_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  ctl_e             state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [AddrW-1:0] last_q, last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      addr_q  <= '0;
      last_q  <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      last_q  <= last_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    addr_d        = addr_q;
    last_d        = last_q;
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    cmd_o.rd_addr = addr_q;
    case (state_q)
      C_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.take    = s_axis_tvalid;
        if (s_axis_tvalid) begin
          if (stat_i.walk) begin
            state_d = C_WALK;
            addr_d  = '0;
            last_d  = stat_i.last_addr;
          end else if (stat_i.direct) begin
            state_d = C_EVAL;
          end
        end
      end
      C_WALK: begin
        cmd_o.rd_en = 1'b1;
        if (addr_q == last_q) begin
          state_d = C_TAIL;
        end else begin
          addr_d = addr_q + AddrW'(1);
        end
      end
      C_TAIL: begin
        state_d = C_EVAL;
      end
      C_EVAL: begin
        if (stat_i.out_free) begin
          cmd_o.eval = 1'b1;
          state_d    = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/gl3ns_dp.sv
// Datapath: message buffer, byte walk accumulators, session registers, output word.
`timescale 1ns / 1ps
`default_nettype none
module gl3ns_dp
  import gl3ns_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] s_axis_tdata,
  input  wire logic [2:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,
  output logic      [4:0]  m_axis_tuser,
  input  wire logic        cfg_valid_i,
  input  wire logic [0:0]  cfg_addr_i,
  input  wire logic [4:0]  cfg_data_i,
  input  wire cmd_t        cmd_i,
  output stat_t            stat_o
);

  // input word fields
  act_e            in_act;
  logic            in_byte_act;
  logic [CntW-1:0] len_new;

  // buffer
  logic [7:0]       rdata;
  logic             rd_vld_q;
  logic [AddrW-1:0] idx_q;

  // item latch
  act_e            it_act_q;
  logic [1:0]      it_sapi_q;
  svc_e            it_svc_q;
  logic            it_aok_q;
  logic [CntW-1:0] len_q;

  // walk accumulators
  logic [7:0]     b0_q, b1_q, b2_q, b3_q, b4_q, b5_q, b9_q;
  logic [IdW-1:0] idc_q;
  logic [7:0]     idl_q;
  logic           cm_hit_q;
  logic [9:0]     nxt_q, nxt_d;
  ie_e            ie_q, ie_d;
  logic [7:0]     ieid_q, ieid_d;
  logic           speech_q, speech_d, called_q, called_d;
  logic [8:0]     cm_off;

  // session registers
  sess_e           sess_q, sess_d;
  logic [CntW-1:0] rx_cnt_q, rx_cnt_d;
  logic [7:0]      est_b0_q, est_b0_d, est_b1_q, est_b1_d, est_b9_q, est_b9_d;
  logic [IdW-1:0]  est_id_q, est_id_d, id_q, id_d;
  logic [CntW-1:0] est_len_q, est_len_d;
  logic            idv_q, idv_d, rel_q, rel_d, alert_q, alert_d;
  logic            asg_q, asg_d, mo_q, mo_d;
  logic [7:0]      txn_q, txn_d;
  svc_e            psvc_q, psvc_d;
  logic [3:0]      part_q, part_d;
  kind_e           pkind_q, pkind_d;
  logic [1:0]      psapi_q, psapi_d;
  logic            auth_req_q;
  logic [4:0]      spc_q;

  // result
  logic  res_acc;
  kind_e res_kind;
  logic  mvalid_q;
  logic  [23:0] mdata_q;
  kind_e mkind_q;

  // evaluation terms
  logic [3:0] pd;
  logic [5:0] mt;
  logic       len_ok, lu, pr, cm, cm_ok, setup_ok, sms_ok, more;
  logic       cc_state;

  assign in_act      = act_e'(s_axis_tuser);
  assign in_byte_act = (in_act == ACT_EST) || (in_act == ACT_RCV);
  assign len_new     = rx_cnt_q + CntW'(rx_cnt_q <= CntW'(MaxMsgBytes));

  always_comb begin
    stat_o           = '0;
    stat_o.walk      = in_byte_act && s_axis_tlast && (len_new >= CntW'(2)) &&
                       (len_new <= CntW'(MaxMsgBytes));
    stat_o.direct    = (in_byte_act && s_axis_tlast && !stat_o.walk) ||
                       (in_act == ACT_PAGE) || (in_act == ACT_CONT) ||
                       (in_act == ACT_ACK) || (in_act == ACT_BEGIN);
    stat_o.last_addr = AddrW'(len_new - CntW'(1));
    stat_o.out_free  = !mvalid_q || m_axis_tready;
  end

  gl3ns_ram #(
    .Width(8),
    .Depth(MaxMsgBytes)
  ) u_rx_buf (
    .clk_i  (clk_i),
    .we_i   (cmd_i.take && in_byte_act && (rx_cnt_q < CntW'(MaxMsgBytes))),
    .waddr_i(rx_cnt_q[AddrW-1:0]),
    .wdata_i(s_axis_tdata[7:0]),
    .re_i   (cmd_i.rd_en),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(rdata)
  );

  assign rx_cnt_d = (cmd_i.take && in_byte_act) ? (s_axis_tlast ? '0 : len_new) : rx_cnt_q;

  // setup information element walk
  assign cm_off = 9'd4 + {1'b0, b3_q};

  always_comb begin
    nxt_d    = nxt_q;
    ie_d     = ie_q;
    ieid_d   = ieid_q;
    speech_d = speech_q;
    called_d = called_q;
    if (rd_vld_q && (idx_q >= AddrW'(2))) begin
      case (ie_q)
        IE_ID: begin
          if (nxt_q == 10'(idx_q)) begin
            if (rdata[7]) begin
              nxt_d = nxt_q + 10'd1;
            end else begin
              ieid_d = rdata;
              ie_d   = IE_VL;
            end
          end
        end
        IE_VL: begin
          nxt_d = nxt_q + 10'd2 + {2'b0, rdata};
          if (ieid_q == IeCalled && rdata >= 8'd2) begin
            called_d = 1'b1;
          end
          if (ieid_q == IeBearer && rdata >= 8'd1) begin
            ie_d = IE_V0;
          end else begin
            ie_d = IE_ID;
          end
        end
        IE_V0: begin
          speech_d = (rdata[2:0] == 3'd0);
          ie_d     = IE_ID;
        end
        default: begin
          ie_d = IE_ID;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_vld_q <= cmd_i.rd_en;
    idx_q    <= cmd_i.rd_addr;
    if (cmd_i.take) begin
      it_act_q  <= in_act;
      it_sapi_q <= s_axis_tdata[9:8];
      it_svc_q  <= svc_e'(s_axis_tdata[11:10]);
      it_aok_q  <= s_axis_tdata[12];
      len_q     <= len_new;
      nxt_q     <= 10'd2;
      ie_q      <= IE_ID;
      ieid_q    <= '0;
      speech_q  <= 1'b0;
      called_q  <= 1'b0;
      cm_hit_q  <= 1'b0;
    end else begin
      nxt_q    <= nxt_d;
      ie_q     <= ie_d;
      ieid_q   <= ieid_d;
      speech_q <= speech_d;
      called_q <= called_d;
      if (rd_vld_q) begin
        case (idx_q)
          AddrW'(0): b0_q <= rdata;
          AddrW'(1): b1_q <= rdata;
          AddrW'(2): b2_q <= rdata;
          AddrW'(3): b3_q <= rdata;
          AddrW'(4): b4_q <= rdata;
          AddrW'(5): b5_q <= rdata;
          AddrW'(IdLenPos): b9_q <= rdata;
          default: ;
        endcase
        for (int k = 0; k < IdentityBytes; k++) begin
          if (idx_q == AddrW'(IdOffset + k)) begin
            idc_q[8*k +: 8] <= rdata;
          end
        end
        if (cm_off == 9'(idx_q)) begin
          idl_q    <= rdata;
          cm_hit_q <= 1'b1;
        end
      end
    end
  end

  // message checks
  assign pd       = b0_q[3:0];
  assign mt       = b1_q[5:0];
  assign len_ok   = (len_q >= CntW'(2)) && (len_q <= CntW'(MaxMsgBytes));
  assign lu       = (sess_q == S_IDLE) && (pd == PdMm) && (mt == MtLuReq);
  assign pr       = (sess_q == S_PAGE_RESP) && (pd == PdRr) && (mt == MtPageResp);
  assign cm       = (sess_q == S_IDLE) && (pd == PdMm) && (mt == MtCmReq) &&
                    (len_q >= CntW'(6)) && (b2_q[3:0] == 4'h1);
  assign cm_ok    = cm_hit_q && (idl_q != 8'd0) && (idl_q <= 8'(IdentityBytes)) &&
                    ({1'b0, cm_off} + 10'd1 + {2'b0, idl_q} <= 10'(len_q));
  assign setup_ok = (ie_q == IE_ID) && (nxt_q <= 10'(len_q)) && speech_q && called_q &&
                    !b0_q[7];
  assign sms_ok   = (mt == MtCpData) && (len_q >= CntW'(6)) && (b2_q == 8'h01) &&
                    (b3_q == 8'h02) && (b4_q == 8'h02) && (b5_q == {RpHigh, part_q});
  assign more     = (psvc_q == SVC_SMART) && (part_q < 4'd15) &&
                    ({1'b0, part_q} + 5'd1 < spc_q);
  assign cc_state = (sess_q == S_ACTIVE) || (sess_q == S_TRAFFIC) ||
                    (sess_q == S_ASSIGN_DONE) || (sess_q == S_INSETUP_ACK);

  always_comb begin
    sess_d    = sess_q;
    est_b0_d  = est_b0_q;
    est_b1_d  = est_b1_q;
    est_b9_d  = est_b9_q;
    est_id_d  = est_id_q;
    est_len_d = est_len_q;
    id_d      = id_q;
    idv_d     = idv_q;
    rel_d     = rel_q;
    alert_d   = alert_q;
    asg_d     = asg_q;
    mo_d      = mo_q;
    txn_d     = txn_q;
    psvc_d    = psvc_q;
    part_d    = part_q;
    pkind_d   = pkind_q;
    psapi_d   = psapi_q;
    res_acc   = 1'b1;
    res_kind  = K_NONE;
    case (it_act_q)
      ACT_EST: begin
        if (len_ok && (lu || pr || (cm && cm_ok))) begin
          est_b0_d  = b0_q;
          est_b1_d  = b1_q;
          est_b9_d  = b9_q;
          est_id_d  = idc_q;
          est_len_d = len_q;
          pkind_d   = K_NONE;
          psapi_d   = 2'd0;
          rel_d     = lu;
          mo_d      = cm;
          txn_d     = 8'd0;
          asg_d     = 1'b0;
          sess_d    = pr ? S_PAGE_CONT : S_CONT;
        end else begin
          res_acc = 1'b0;
        end
      end
      ACT_PAGE: begin
        if (sess_q == S_PAGE_RESP) begin
          res_acc = 1'b1;
        end else if (sess_q != S_IDLE || !idv_q) begin
          res_acc = 1'b0;
        end else begin
          psvc_d = it_svc_q;
          asg_d  = 1'b0;
          if (it_svc_q != SVC_SMART) begin
            part_d = 4'd0;
          end
          sess_d = S_PAGE_RESP;
        end
      end
      ACT_CONT: begin
        if (sess_q == S_PAGE_CONT) begin
          psapi_d = 2'd0;
          if (psvc_q != SVC_NONE) begin
            sess_d   = S_CIPHER_ACK;
            res_kind = K_CIPHER;
          end else begin
            sess_d   = S_CHREL_ACK;
            res_kind = K_CHAN_REL;
          end
          pkind_d = res_kind;
        end else if (sess_q == S_CONT) begin
          psapi_d = 2'd0;
          if (est_b0_q[3:0] == PdMm && est_b1_q[5:0] == MtCmReq) begin
            sess_d   = S_CMACC_ACK;
            res_kind = K_CM_ACCEPT;
          end else if (auth_req_q) begin
            sess_d   = S_AREQ_ACK;
            res_kind = K_AUTH_REQ;
          end else begin
            sess_d   = S_LUACC_ACK;
            res_kind = K_LU_ACCEPT;
          end
          pkind_d = res_kind;
        end
      end
      ACT_ACK: begin
        if (sess_q == S_CMACC_ACK && pkind_q == K_CM_ACCEPT) begin
          pkind_d = K_NONE;
          psapi_d = 2'd0;
          sess_d  = S_OUT_SETUP;
        end else if (sess_q == S_PROC_ACK && pkind_q == K_CALL_PROC) begin
          asg_d    = 1'b1;
          sess_d   = S_TRAFFIC;
          res_kind = K_TRAFFIC;
          pkind_d  = K_TRAFFIC;
          psapi_d  = 2'd0;
        end else if (sess_q == S_ALERT_ACK && pkind_q == K_CALL_ALERT) begin
          sess_d   = S_OCONN_ACK;
          res_kind = K_CALL_CONN;
          pkind_d  = K_CALL_CONN;
          psapi_d  = 2'd0;
        end else if ((sess_q == S_OCONN_ACK && pkind_q == K_CALL_CONN) ||
                     (sess_q == S_TRAFFIC && pkind_q == K_TRAFFIC)) begin
          pkind_d = K_NONE;
          psapi_d = 2'd0;
        end else if (sess_q == S_AREQ_ACK && pkind_q == K_AUTH_REQ) begin
          pkind_d = K_NONE;
          psapi_d = 2'd0;
          sess_d  = S_AUTH_RESP;
        end else if (sess_q == S_AREJ_ACK && pkind_q == K_AUTH_REJ) begin
          rel_d    = 1'b0;
          sess_d   = S_CHREL_ACK;
          res_kind = K_CHAN_REL;
          pkind_d  = K_CHAN_REL;
          psapi_d  = 2'd0;
        end else if ((sess_q == S_LUACC_ACK && pkind_q == K_LU_ACCEPT) ||
                     (sess_q == S_CPACK_ACK && pkind_q == K_SMS_ACK) ||
                     (sess_q == S_CREL_ACK && pkind_q == K_CALL_REL)) begin
          sess_d   = S_CHREL_ACK;
          res_kind = K_CHAN_REL;
          pkind_d  = K_CHAN_REL;
          psapi_d  = 2'd0;
        end else if (sess_q == S_INSETUP_ACK && pkind_q == K_IN_SETUP) begin
          pkind_d = K_NONE;
          psapi_d = 2'd0;
          sess_d  = S_ACTIVE;
        end else if (sess_q == S_CIPHER_ACK && pkind_q == K_CIPHER) begin
          sess_d   = S_MMINFO_ACK;
          res_kind = K_MM_INFO;
          pkind_d  = K_MM_INFO;
          psapi_d  = 2'd0;
        end else if (sess_q == S_MMINFO_ACK && pkind_q == K_MM_INFO) begin
          if (psvc_q == SVC_CALL) begin
            sess_d   = S_INSETUP_ACK;
            res_kind = K_IN_SETUP;
            pkind_d  = K_IN_SETUP;
            psapi_d  = 2'd0;
          end else if (psvc_q == SVC_SMS || psvc_q == SVC_SMART) begin
            sess_d   = S_SAPI3;
            res_kind = K_SAPI3_EST;
            pkind_d  = K_SAPI3_EST;
            psapi_d  = 2'd3;
          end
        end else if (sess_q == S_SAPI3 && pkind_q == K_SAPI3_EST) begin
          sess_d   = S_CPDATA_ACK;
          res_kind = K_SMS_DATA;
          pkind_d  = K_SMS_DATA;
          psapi_d  = 2'd3;
        end else if (sess_q == S_CPDATA_ACK && pkind_q == K_SMS_DATA) begin
          pkind_d = K_NONE;
          psapi_d = 2'd0;
          sess_d  = S_SMS_RESP;
        end else if (sess_q == S_CONNACK_ACK && pkind_q == K_CONN_ACK) begin
          pkind_d = K_NONE;
          psapi_d = 2'd0;
          sess_d  = S_ACTIVE;
        end else if (sess_q == S_CHREL_ACK && pkind_q == K_CHAN_REL) begin
          if (rel_q && est_len_q >= CntW'(IdMinLen) && est_b9_q == 8'(IdentityBytes)) begin
            id_d  = est_id_q;
            idv_d = 1'b1;
          end
          pkind_d = K_NONE;
          psapi_d = 2'd0;
          if (more) begin
            part_d = part_q + 4'd1;
          end
          if (psvc_q == SVC_CALL) begin
            sess_d = S_REL_COMPLETE;
          end else begin
            est_b0_d  = '0;
            est_b1_d  = '0;
            est_b9_d  = '0;
            est_id_d  = '0;
            est_len_d = '0;
            rel_d     = 1'b0;
            if (!more) begin
              psvc_d = SVC_NONE;
              part_d = 4'd0;
            end
            sess_d   = S_IDLE;
            res_kind = K_REL_COMPLETE;
          end
        end
      end
      ACT_RCV: begin
        if (len_ok) begin
          if (it_sapi_q == 2'd0 && sess_q == S_OUT_SETUP && pd == PdCc && mt == MtSetup) begin
            if (setup_ok) begin
              txn_d    = b0_q;
              sess_d   = S_PROC_ACK;
              res_kind = K_CALL_PROC;
              pkind_d  = K_CALL_PROC;
              psapi_d  = 2'd0;
            end
          end else if (it_sapi_q == 2'd0 && sess_q == S_AUTH_RESP) begin
            psapi_d = 2'd0;
            if (it_aok_q) begin
              sess_d   = S_LUACC_ACK;
              res_kind = K_LU_ACCEPT;
            end else begin
              sess_d   = S_AREJ_ACK;
              res_kind = K_AUTH_REJ;
            end
            pkind_d = res_kind;
          end else if (it_sapi_q == 2'd0 && pd == PdCc && cc_state &&
                       (mt == MtCallConf || mt == MtAlerting || mt == MtConnect ||
                        mt == MtDisconnect)) begin
            if (mt == MtCallConf) begin
              if (sess_q == S_ACTIVE && !asg_q) begin
                asg_d    = 1'b1;
                sess_d   = S_TRAFFIC;
                res_kind = K_TRAFFIC;
                pkind_d  = K_TRAFFIC;
                psapi_d  = 2'd0;
              end
            end else if (mt == MtAlerting) begin
              alert_d = 1'b1;
            end else if (mt == MtConnect) begin
              alert_d  = 1'b0;
              sess_d   = S_CONNACK_ACK;
              res_kind = K_CONN_ACK;
              pkind_d  = K_CONN_ACK;
              psapi_d  = 2'd0;
            end else begin
              alert_d  = 1'b0;
              sess_d   = S_CREL_ACK;
              res_kind = K_CALL_REL;
              pkind_d  = K_CALL_REL;
              psapi_d  = 2'd0;
            end
          end else if (it_sapi_q == 2'd0 && sess_q == S_ASSIGN_DONE && pd == PdRr &&
                       mt == MtAssignDone) begin
            if (mo_q) begin
              alert_d  = 1'b1;
              sess_d   = S_ALERT_ACK;
              res_kind = K_CALL_ALERT;
              pkind_d  = K_CALL_ALERT;
              psapi_d  = 2'd0;
            end else begin
              sess_d = S_ACTIVE;
            end
          end else if (it_sapi_q == 2'd0 && sess_q == S_OCONN_ACK && pd == PdCc &&
                       mt == MtConnAck) begin
            pkind_d = K_NONE;
            psapi_d = 2'd0;
            alert_d = 1'b0;
            sess_d  = S_ACTIVE;
          end else if (sess_q == S_REL_COMPLETE && pd == PdCc && mt == MtRelCompl) begin
            est_b0_d  = '0;
            est_b1_d  = '0;
            est_b9_d  = '0;
            est_id_d  = '0;
            est_len_d = '0;
            rel_d     = 1'b0;
            alert_d   = 1'b0;
            asg_d     = 1'b0;
            mo_d      = 1'b0;
            txn_d     = 8'd0;
            psvc_d    = SVC_NONE;
            sess_d    = S_IDLE;
            res_kind  = K_REL_COMPLETE;
          end else if (it_sapi_q == 2'd3 && sess_q == S_SMS_RESP && pd == PdSms &&
                       mt != MtCpAck && sms_ok) begin
            sess_d   = S_CPACK_ACK;
            res_kind = K_SMS_ACK;
            pkind_d  = K_SMS_ACK;
            psapi_d  = 2'd3;
          end
        end
      end
      ACT_BEGIN: begin
        if (sess_q == S_TRAFFIC) begin
          pkind_d = K_NONE;
          psapi_d = 2'd0;
          sess_d  = S_ASSIGN_DONE;
        end else begin
          res_acc = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_cnt_q   <= '0;
      sess_q     <= S_IDLE;
      est_b0_q   <= '0;
      est_b1_q   <= '0;
      est_b9_q   <= '0;
      est_id_q   <= '0;
      est_len_q  <= '0;
      id_q       <= '0;
      idv_q      <= 1'b0;
      rel_q      <= 1'b0;
      alert_q    <= 1'b0;
      asg_q      <= 1'b0;
      mo_q       <= 1'b0;
      txn_q      <= '0;
      psvc_q     <= SVC_NONE;
      part_q     <= '0;
      pkind_q    <= K_NONE;
      psapi_q    <= '0;
      auth_req_q <= 1'b0;
      spc_q      <= 5'd1;
      mvalid_q   <= 1'b0;
    end else begin
      rx_cnt_q <= rx_cnt_d;
      if (cmd_i.eval) begin
        sess_q    <= sess_d;
        est_b0_q  <= est_b0_d;
        est_b1_q  <= est_b1_d;
        est_b9_q  <= est_b9_d;
        est_id_q  <= est_id_d;
        est_len_q <= est_len_d;
        id_q      <= id_d;
        idv_q     <= idv_d;
        rel_q     <= rel_d;
        alert_q   <= alert_d;
        asg_q     <= asg_d;
        mo_q      <= mo_d;
        txn_q     <= txn_d;
        psvc_q    <= psvc_d;
        part_q    <= part_d;
        pkind_q   <= pkind_d;
        psapi_q   <= psapi_d;
      end
      if (cfg_valid_i) begin
        if (reg_e'(cfg_addr_i) == REG_AUTH_REQ) begin
          auth_req_q <= cfg_data_i[0];
        end else begin
          spc_q <= cfg_data_i;
        end
      end
      if (cmd_i.eval) begin
        mvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        mvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      mkind_q <= res_kind;
      mdata_q <= {2'b0, part_d, txn_d, idv_d, sess_d, alert_d,
                  ((res_kind != K_NONE && res_kind != K_REL_COMPLETE) ? psapi_d : 2'd0),
                  res_acc};
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = mkind_q;

endmodule
`default_nettype wire

// File: hdl/gsm_l3_network_session_fsm.sv
// Top level of the network-side GSM layer-3 session sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Takes uplink message bytes and session events one word at a time and returns one
// result word per event and per message-closing byte (tlast). A byte without tlast is
// taken and gives no result. A closing byte that ends a message of 2 to 32 bytes has
// the message buffer (one RAM, one read port) walked one byte per cycle for the message
// and information element checks; an event or any other closing byte goes straight to
// evaluation. A finished result sits in an output register; the next word is taken
// while it waits, and evaluation stalls only if a new result is due before the previous
// one is taken. Configuration writes are always ready and are meant for idle periods.
module gsm_l3_network_session_fsm
  import gl3ns_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // data_byte[7:0], link_sapi[9:8], page_service[11:10], auth_ok[12], zero[15:13]
  input  wire logic [15:0] s_axis_tdata,
  // action[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // accepted[0], send_sapi[2:1], alerting[3], session_code[8:4], registered[9],
  // transaction_byte[17:10], smart_part[21:18], zero[23:22]
  output logic      [23:0] m_axis_tdata,
  // send_kind[4:0]
  output logic      [4:0]  m_axis_tuser,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [0:0]  cfg_addr_i,
  input  wire logic [4:0]  cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  gl3ns_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  gl3ns_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule
`default_nettype wire

// File: tb/gsm_l3_network_session_fsm_test.sv
// Self-checking testbench of the layer-3 network session sequencer.
`timescale 1ns / 1ps
`default_nettype none
module gsm_l3_network_session_fsm_test;
  import gl3ns_pkg::*;

  localparam logic [1:0] SapiMain = 2'd0;
  localparam logic [1:0] SapiSms  = 2'd3;
  localparam int         DrainCyc = 60;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] dat;
    logic       lst;
    logic [1:0] sapi;
    logic [1:0] svc;
    logic       aok;
  } word_t;

  typedef struct packed {
    logic       acc;
    kind_e      kind;
    logic [1:0] sapi;
    logic       alert;
    sess_e      code;
    logic       regd;
    logic [7:0] txn;
    logic [3:0] part;
  } rslt_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [4:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_addr_i = '0;
  logic [4:0]  cfg_data_i = '0;

  gsm_l3_network_session_fsm u_top (.*);

  always #4 clk_i = ~clk_i;

  // index 0 tracks the block, index 1 runs ahead to steer stimulus
  sess_e      sess [2];
  logic [7:0] rxb [2][MaxMsgBytes];
  int         rxn [2];
  logic [7:0] estb [2][MaxMsgBytes];
  int         estn [2];
  logic [IdW-1:0] idst [2];
  logic       idv [2], relreg [2], alrt [2], asg [2], mo [2];
  logic [7:0] txn [2];
  svc_e       psvc [2];
  logic [3:0] part [2];
  kind_e      pk [2];
  logic [1:0] ps [2];
  logic       authq [2];
  logic [4:0] pcnt [2];

  word_t      pending_words [$];
  rslt_t      due_results [$];
  logic [7:0] msg [$];
  word_t      cur_word;
  int         send_idle = 0, recv_stall = 0, n_items = 0, errs = 0;

  function automatic kind_e put(int u, kind_e k, logic [1:0] sp);
    pk[u] = k;
    ps[u] = sp;
    return k;
  endfunction

  function automatic void clear_est(int u);
    for (int i = 0; i < MaxMsgBytes; i++) estb[u][i] = '0;
    estn[u] = 0;
    relreg[u] = 1'b0;
  endfunction

  function automatic logic establish(int u, int len);
    logic [3:0] pd;
    logic [5:0] mt;
    bit lu, pr, cm;
    int off, idl;
    if (len < 2 || len > MaxMsgBytes) return 1'b0;
    pd = rxb[u][0][3:0];
    mt = rxb[u][1][5:0];
    lu = sess[u] == S_IDLE && pd == PdMm && mt == MtLuReq;
    pr = sess[u] == S_PAGE_RESP && pd == PdRr && mt == MtPageResp;
    cm = sess[u] == S_IDLE && pd == PdMm && mt == MtCmReq && len >= 6 &&
         rxb[u][2][3:0] == 4'h1;
    if (!lu && !pr && !cm) return 1'b0;
    if (cm) begin
      off = 4 + rxb[u][3];
      if (off >= len) return 1'b0;
      idl = rxb[u][off];
      if (idl == 0 || idl > IdentityBytes || off + 1 + idl > len) return 1'b0;
    end
    for (int i = 0; i < MaxMsgBytes; i++) estb[u][i] = (i < len) ? rxb[u][i] : 8'h00;
    estn[u] = len;
    void'(put(u, K_NONE, 2'd0));
    relreg[u] = lu;
    mo[u] = cm;
    txn[u] = '0;
    asg[u] = 1'b0;
    sess[u] = pr ? S_PAGE_CONT : S_CONT;
    return 1'b1;
  endfunction

  function automatic logic page(int u, svc_e svc);
    if (sess[u] == S_PAGE_RESP) return 1'b1;
    if (sess[u] != S_IDLE || !idv[u]) return 1'b0;
    psvc[u] = svc;
    asg[u] = 1'b0;
    if (svc != SVC_SMART) part[u] = '0;
    sess[u] = S_PAGE_RESP;
    return 1'b1;
  endfunction

  function automatic kind_e contention(int u);
    if (sess[u] == S_PAGE_CONT) begin
      if (psvc[u] != SVC_NONE) begin
        sess[u] = S_CIPHER_ACK;
        return put(u, K_CIPHER, SapiMain);
      end
      sess[u] = S_CHREL_ACK;
      return put(u, K_CHAN_REL, SapiMain);
    end
    if (sess[u] != S_CONT) return K_NONE;
    if (estb[u][0][3:0] == PdMm && estb[u][1][5:0] == MtCmReq) begin
      sess[u] = S_CMACC_ACK;
      return put(u, K_CM_ACCEPT, SapiMain);
    end
    if (authq[u]) begin
      sess[u] = S_AREQ_ACK;
      return put(u, K_AUTH_REQ, SapiMain);
    end
    sess[u] = S_LUACC_ACK;
    return put(u, K_LU_ACCEPT, SapiMain);
  endfunction

  function automatic kind_e ack(int u);
    sess_e s;
    kind_e p;
    bit more;
    s = sess[u];
    p = pk[u];
    if (s == S_CMACC_ACK && p == K_CM_ACCEPT) begin
      sess[u] = S_OUT_SETUP;
      return put(u, K_NONE, 2'd0);
    end
    if (s == S_PROC_ACK && p == K_CALL_PROC) begin
      asg[u] = 1'b1;
      sess[u] = S_TRAFFIC;
      return put(u, K_TRAFFIC, SapiMain);
    end
    if (s == S_ALERT_ACK && p == K_CALL_ALERT) begin
      sess[u] = S_OCONN_ACK;
      return put(u, K_CALL_CONN, SapiMain);
    end
    if (s == S_OCONN_ACK && p == K_CALL_CONN) return put(u, K_NONE, 2'd0);
    if (s == S_AREQ_ACK && p == K_AUTH_REQ) begin
      sess[u] = S_AUTH_RESP;
      return put(u, K_NONE, 2'd0);
    end
    if (s == S_AREJ_ACK && p == K_AUTH_REJ) begin
      relreg[u] = 1'b0;
      sess[u] = S_CHREL_ACK;
      return put(u, K_CHAN_REL, SapiMain);
    end
    if (s == S_LUACC_ACK && p == K_LU_ACCEPT) begin
      sess[u] = S_CHREL_ACK;
      return put(u, K_CHAN_REL, SapiMain);
    end
    if (s == S_INSETUP_ACK && p == K_IN_SETUP) begin
      sess[u] = S_ACTIVE;
      return put(u, K_NONE, 2'd0);
    end
    if (s == S_TRAFFIC && p == K_TRAFFIC) return put(u, K_NONE, 2'd0);
    if (s == S_CIPHER_ACK && p == K_CIPHER) begin
      sess[u] = S_MMINFO_ACK;
      return put(u, K_MM_INFO, SapiMain);
    end
    if (s == S_MMINFO_ACK && p == K_MM_INFO) begin
      if (psvc[u] == SVC_CALL) begin
        sess[u] = S_INSETUP_ACK;
        return put(u, K_IN_SETUP, SapiMain);
      end
      if (psvc[u] == SVC_SMS || psvc[u] == SVC_SMART) begin
        sess[u] = S_SAPI3;
        return put(u, K_SAPI3_EST, SapiSms);
      end
    end
    if (s == S_SAPI3 && p == K_SAPI3_EST) begin
      sess[u] = S_CPDATA_ACK;
      return put(u, K_SMS_DATA, SapiSms);
    end
    if (s == S_CPDATA_ACK && p == K_SMS_DATA) begin
      sess[u] = S_SMS_RESP;
      return put(u, K_NONE, 2'd0);
    end
    if ((s == S_CPACK_ACK && p == K_SMS_ACK) || (s == S_CREL_ACK && p == K_CALL_REL)) begin
      sess[u] = S_CHREL_ACK;
      return put(u, K_CHAN_REL, SapiMain);
    end
    if (s == S_CONNACK_ACK && p == K_CONN_ACK) begin
      sess[u] = S_ACTIVE;
      return put(u, K_NONE, 2'd0);
    end
    if (s == S_CHREL_ACK && p == K_CHAN_REL) begin
      if (relreg[u] && estn[u] >= IdMinLen && estb[u][IdLenPos] == IdentityBytes) begin
        for (int i = 0; i < IdentityBytes; i++) idst[u][8*i +: 8] = estb[u][IdOffset + i];
        idv[u] = 1'b1;
      end
      void'(put(u, K_NONE, 2'd0));
      more = psvc[u] == SVC_SMART && part[u] < 4'd15 && int'(part[u]) + 1 < int'(pcnt[u]);
      if (more) part[u] = part[u] + 4'd1;
      if (psvc[u] == SVC_CALL) begin
        sess[u] = S_REL_COMPLETE;
        return K_NONE;
      end
      clear_est(u);
      if (!more) begin
        psvc[u] = SVC_NONE;
        part[u] = '0;
      end
      sess[u] = S_IDLE;
      return K_REL_COMPLETE;
    end
    return K_NONE;
  endfunction

  function automatic kind_e call_setup(int u, int len);
    bit speech, called;
    int off, vl;
    logic [7:0] id;
    speech = 0;
    called = 0;
    off = 2;
    while (off < len) begin
      id = rxb[u][off];
      if (id[7]) begin
        off++;
        continue;
      end
      if (off + 1 >= len) return K_NONE;
      vl = rxb[u][off + 1];
      if (off + 2 + vl > len) return K_NONE;
      if (id == IeBearer && vl >= 1) speech = rxb[u][off + 2][2:0] == 3'd0;
      else if (id == IeCalled && vl >= 2) called = 1;
      off += 2 + vl;
    end
    if (!speech || !called || rxb[u][0][7]) return K_NONE;
    txn[u] = rxb[u][0];
    sess[u] = S_PROC_ACK;
    return put(u, K_CALL_PROC, SapiMain);
  endfunction

  function automatic kind_e receive(int u, logic [1:0] sp, int len, logic aok);
    logic [3:0] pd;
    logic [5:0] mt;
    sess_e s;
    if (len < 2 || len > MaxMsgBytes) return K_NONE;
    pd = rxb[u][0][3:0];
    mt = rxb[u][1][5:0];
    s = sess[u];
    if (sp == SapiMain && s == S_OUT_SETUP && pd == PdCc && mt == MtSetup)
      return call_setup(u, len);
    if (sp == SapiMain && s == S_AUTH_RESP) begin
      if (aok) begin
        sess[u] = S_LUACC_ACK;
        return put(u, K_LU_ACCEPT, SapiMain);
      end
      sess[u] = S_AREJ_ACK;
      return put(u, K_AUTH_REJ, SapiMain);
    end
    if (sp == SapiMain && pd == PdCc && (s == S_ACTIVE || s == S_TRAFFIC ||
        s == S_ASSIGN_DONE || s == S_INSETUP_ACK)) begin
      if (mt == MtCallConf) begin
        if (s != S_ACTIVE || asg[u]) return K_NONE;
        asg[u] = 1'b1;
        sess[u] = S_TRAFFIC;
        return put(u, K_TRAFFIC, SapiMain);
      end
      if (mt == MtAlerting) begin
        alrt[u] = 1'b1;
        return K_NONE;
      end
      if (mt == MtConnect) begin
        alrt[u] = 1'b0;
        sess[u] = S_CONNACK_ACK;
        return put(u, K_CONN_ACK, SapiMain);
      end
      if (mt == MtDisconnect) begin
        alrt[u] = 1'b0;
        sess[u] = S_CREL_ACK;
        return put(u, K_CALL_REL, SapiMain);
      end
    end
    if (sp == SapiMain && s == S_ASSIGN_DONE && pd == PdRr && mt == MtAssignDone) begin
      if (mo[u]) begin
        alrt[u] = 1'b1;
        sess[u] = S_ALERT_ACK;
        return put(u, K_CALL_ALERT, SapiMain);
      end
      sess[u] = S_ACTIVE;
      return K_NONE;
    end
    if (sp == SapiMain && s == S_OCONN_ACK && pd == PdCc && mt == MtConnAck) begin
      alrt[u] = 1'b0;
      sess[u] = S_ACTIVE;
      return put(u, K_NONE, 2'd0);
    end
    if (s == S_REL_COMPLETE && pd == PdCc && mt == MtRelCompl) begin
      clear_est(u);
      alrt[u] = 1'b0;
      asg[u] = 1'b0;
      mo[u] = 1'b0;
      txn[u] = '0;
      psvc[u] = SVC_NONE;
      sess[u] = S_IDLE;
      return K_REL_COMPLETE;
    end
    if (sp == SapiSms && s == S_SMS_RESP && pd == PdSms) begin
      if (mt == MtCpAck) return K_NONE;
      if (mt == MtCpData && len >= 6 && rxb[u][2] == 8'h01 && rxb[u][3] == 8'h02 &&
          rxb[u][4] == 8'h02 && rxb[u][5] == {RpHigh, part[u]}) begin
        sess[u] = S_CPACK_ACK;
        return put(u, K_SMS_ACK, SapiSms);
      end
    end
    return K_NONE;
  endfunction

  function automatic bit session_step(int u, word_t w, output rslt_t r);
    int len;
    logic acc;
    kind_e k;
    acc = 1'b1;
    k = K_NONE;
    r = '0;
    case (act_e'(w.act))
      ACT_EST, ACT_RCV: begin
        if (rxn[u] < MaxMsgBytes) rxb[u][rxn[u]] = w.dat;
        if (rxn[u] <= MaxMsgBytes) rxn[u]++;
        if (!w.lst) return 0;
        len = rxn[u];
        rxn[u] = 0;
        if (act_e'(w.act) == ACT_EST) acc = establish(u, len);
        else k = receive(u, w.sapi, len, w.aok);
      end
      ACT_PAGE: acc = page(u, svc_e'(w.svc));
      ACT_CONT: k = contention(u);
      ACT_ACK: k = ack(u);
      ACT_BEGIN: begin
        if (sess[u] != S_TRAFFIC) acc = 1'b0;
        else begin
          void'(put(u, K_NONE, 2'd0));
          sess[u] = S_ASSIGN_DONE;
        end
      end
      default: return 0;
    endcase
    r.acc = acc;
    r.kind = k;
    r.sapi = (k != K_NONE && k != K_REL_COMPLETE) ? ps[u] : 2'd0;
    r.alert = alrt[u];
    r.code = sess[u];
    r.regd = idv[u];
    r.txn = txn[u];
    r.part = part[u];
    return 1;
  endfunction

  // ---------------- stimulus ----------------
  function automatic void push_word(word_t w);
    rslt_t r;
    pending_words.push_back(w);
    void'(session_step(1, w, r));
    n_items++;
  endfunction

  function automatic void ev(logic [2:0] a, logic [1:0] svc);
    word_t w;
    w = word_t'(17'($urandom));
    w.act = a;
    w.svc = svc;
    push_word(w);
  endfunction

  function automatic void flush_msg(logic [2:0] a, logic [1:0] sp, logic ok);
    word_t w;
    foreach (msg[i]) begin
      w = word_t'(17'($urandom));
      w.act = a;
      w.dat = msg[i];
      w.lst = i == msg.size() - 1;
      w.sapi = sp;
      w.aok = ok;
      push_word(w);
    end
    msg.delete();
  endfunction

  function automatic logic [7:0] rb();
    return 8'($urandom);
  endfunction

  function automatic void add_rand(int n);
    repeat (n) msg.push_back(rb());
  endfunction

  function automatic void cc_msg(logic [5:0] mt);
    msg.push_back({rb() & 8'hf0 | 8'(PdCc)});
    msg.push_back({2'($urandom), mt});
    add_rand($urandom_range(0, 2));
  endfunction

  function automatic void gen_noise();
    int len;
    case ($urandom_range(0, 4))
      0, 1: ev(3'($urandom_range(2, 7)), 2'($urandom));
      2: begin
        add_rand($urandom_range(1, 5));
        flush_msg(3'($urandom_range(0, 1)), 2'($urandom), 1'($urandom));
      end
      3: begin
        len = $urandom_range(MaxMsgBytes + 1, MaxMsgBytes + 4);
        add_rand(len);
        flush_msg(3'($urandom_range(0, 1)), 2'($urandom), 1'($urandom));
      end
      default: begin
        // partial message, finished later by whatever comes next
        add_rand($urandom_range(1, 2));
        foreach (msg[i]) begin
          word_t w;
          w = word_t'(17'($urandom));
          w.act = 3'($urandom_range(0, 1));
          w.dat = msg[i];
          w.lst = 1'b0;
          push_word(w);
        end
        msg.delete();
      end
    endcase
  endfunction

  function automatic void gen_next();
    int len, l, idl;
    if ($urandom_range(0, 99) < 12) begin
      gen_noise();
      return;
    end
    case (sess[1])
      S_IDLE: begin
        case ($urandom_range(0, 3))
          0: begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 17)
                                              : $urandom_range(IdMinLen, MaxMsgBytes);
            msg.push_back({4'($urandom), PdMm});
            msg.push_back({2'($urandom), MtLuReq});
            add_rand(len - 2);
            if (len > IdLenPos && $urandom_range(0, 9) != 0)
              msg[IdLenPos] = 8'(IdentityBytes);
            flush_msg(ACT_EST, 2'($urandom), 1'($urandom));
          end
          1, 2: begin
            if (idv[1] || $urandom_range(0, 3) == 0) ev(ACT_PAGE, 2'($urandom));
            else gen_noise();
          end
          default: begin
            msg.push_back({4'($urandom), PdMm});
            msg.push_back({2'($urandom), MtCmReq});
            msg.push_back({4'($urandom), 4'h1});
            l = $urandom_range(0, 3);
            msg.push_back(8'(l));
            add_rand(l);
            idl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 9)
                                              : $urandom_range(1, IdentityBytes);
            msg.push_back(8'(idl));
            add_rand(idl - ($urandom_range(0, 7) == 0));
            add_rand($urandom_range(0, 3));
            flush_msg(ACT_EST, 2'($urandom), 1'($urandom));
          end
        endcase
      end
      S_PAGE_RESP: begin
        msg.push_back({4'($urandom), PdRr});
        msg.push_back({2'($urandom), MtPageResp});
        add_rand($urandom_range(0, 4));
        flush_msg(ACT_EST, 2'($urandom), 1'($urandom));
      end
      S_PAGE_CONT, S_CONT: ev(ACT_CONT, 2'($urandom));
      S_OUT_SETUP: begin
        msg.push_back({1'b0, 3'($urandom), PdCc});
        msg.push_back({2'($urandom), MtSetup});
        if ($urandom_range(0, 2) == 0) msg.push_back(8'h80 | rb());
        l = $urandom_range(0, 1);
        for (int j = 0; j < 2; j++) begin
          if (j == l) begin
            msg.push_back(IeBearer);
            msg.push_back(8'd1);
            msg.push_back(($urandom_range(0, 5) == 0) ? rb() : (rb() & 8'hf8));
          end else begin
            msg.push_back(IeCalled);
            idl = $urandom_range(1, 4);
            msg.push_back(8'(idl));
            add_rand(idl);
          end
        end
        if ($urandom_range(0, 5) == 0) msg[0][7] = 1'b1;
        flush_msg(ACT_RCV, SapiMain, 1'($urandom));
      end
      S_AUTH_RESP: begin
        add_rand($urandom_range(2, 4));
        flush_msg(ACT_RCV, SapiMain, 1'($urandom));
      end
      S_TRAFFIC: begin
        if ($urandom_range(0, 1)) ev(ACT_ACK, 2'($urandom));
        else ev(ACT_BEGIN, 2'($urandom));
      end
      S_ASSIGN_DONE: begin
        if ($urandom_range(0, 4) == 0) cc_msg(MtAlerting);
        else begin
          msg.push_back({4'($urandom), PdRr});
          msg.push_back({2'($urandom), MtAssignDone});
        end
        flush_msg(ACT_RCV, SapiMain, 1'($urandom));
      end
      S_ACTIVE: begin
        case ($urandom_range(0, 3))
          0: cc_msg(MtCallConf);
          1: cc_msg(MtAlerting);
          2: cc_msg(MtConnect);
          default: cc_msg(MtDisconnect);
        endcase
        flush_msg(ACT_RCV, SapiMain, 1'($urandom));
      end
      S_OCONN_ACK: begin
        if ($urandom_range(0, 1)) ev(ACT_ACK, 2'($urandom));
        else begin
          cc_msg(MtConnAck);
          flush_msg(ACT_RCV, SapiMain, 1'($urandom));
        end
      end
      S_SMS_RESP: begin
        msg.push_back({4'($urandom), PdSms});
        if ($urandom_range(0, 4) == 0) msg.push_back({2'($urandom), MtCpAck});
        else begin
          msg.push_back({2'($urandom), MtCpData});
          msg.push_back(8'h01);
          msg.push_back(8'h02);
          msg.push_back(8'h02);
          msg.push_back({RpHigh, part[1]});
          add_rand($urandom_range(0, 3));
        end
        flush_msg(ACT_RCV, SapiSms, 1'($urandom));
      end
      S_REL_COMPLETE: begin
        cc_msg(MtRelCompl);
        flush_msg(ACT_RCV, 2'($urandom), 1'($urandom));
      end
      default: ev(ACT_ACK, 2'($urandom));
    endcase
  endfunction

  function automatic void gen_directed();
    ev(3'd6, 2'd0);
    ev(3'd7, 2'd3);
    ev(ACT_PAGE, SVC_SMART);
    ev(ACT_CONT, SVC_NONE);
    ev(ACT_ACK, SVC_CALL);
    ev(ACT_BEGIN, SVC_SMS);
    msg.push_back(8'h00);
    flush_msg(ACT_EST, SapiMain, 1'b0);
    msg.push_back(8'hff);
    flush_msg(ACT_RCV, SapiSms, 1'b1);
    msg.push_back(8'hff);
    msg.push_back(8'hff);
    flush_msg(ACT_EST, 2'd2, 1'b1);
    msg.push_back({4'h0, PdCc});
    msg.push_back({2'b00, MtDisconnect});
    flush_msg(ACT_RCV, SapiMain, 1'b0);
    // byte, event, closing byte of another kind: one shared buffer
    msg.push_back({4'h0, PdMm});
    foreach (msg[i]) push_word('{act: ACT_EST, dat: msg[i], lst: 1'b0, sapi: 2'd1,
                                 svc: 2'd2, aok: 1'b0});
    msg.delete();
    ev(ACT_CONT, SVC_NONE);
    msg.push_back({2'b00, MtLuReq});
    flush_msg(ACT_RCV, SapiMain, 1'b1);
  endfunction

  // ---------------- driver / monitor ----------------
  always @(posedge clk_i) begin
    rslt_t r;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready && session_step(0, cur_word, r))
        due_results.push_back(r);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          cur_word = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {3'b000, cur_word.aok, cur_word.svc, cur_word.sapi, cur_word.dat};
          s_axis_tuser <= cur_word.act;
          s_axis_tlast <= cur_word.lst;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int e, int a);
    if (e != a) begin
      errs++;
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
    end
  endtask

  always @(posedge clk_i) begin
    rslt_t e;
    m_axis_tready <= $urandom_range(0, 99) >= recv_stall;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_results.size() == 0) begin
        errs++;
        $display("%0t unexpected result word: expected none actual %h/%h", $time,
                 m_axis_tuser, m_axis_tdata);
      end else begin
        e = due_results.pop_front();
        check_field("accepted", e.acc, m_axis_tdata[0]);
        check_field("send_kind", e.kind, m_axis_tuser);
        check_field("send_sapi", e.sapi, m_axis_tdata[2:1]);
        check_field("alerting", e.alert, m_axis_tdata[3]);
        check_field("session_code", e.code, m_axis_tdata[8:4]);
        check_field("registered", e.regd, m_axis_tdata[9]);
        check_field("transaction_byte", e.txn, m_axis_tdata[17:10]);
        check_field("smart_part", e.part, m_axis_tdata[21:18]);
      end
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      if (reg_e'(cfg_addr_i) == REG_AUTH_REQ) authq[0] = cfg_data_i[0];
      else pcnt[0] = cfg_data_i;
    end
  end

  task automatic cfg_write(reg_e idx, logic [4:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || s_axis_tvalid || due_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCyc) @(posedge clk_i);
  endtask

  logic       auth_tab [8] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
  logic [4:0] cnt_tab [8] = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd5, 5'd16, 5'd3, 5'd2};
  int         idle_tab [4] = '{0, 82, 0, 36};
  int         stall_tab [4] = '{0, 0, 82, 36};

  initial begin
    int target;
    for (int u = 0; u < 2; u++) begin
      sess[u] = S_IDLE;
      for (int i = 0; i < MaxMsgBytes; i++) rxb[u][i] = '0;
      rxn[u] = 0;
      clear_est(u);
      idst[u] = '0;
      idv[u] = 1'b0;
      alrt[u] = 1'b0;
      asg[u] = 1'b0;
      mo[u] = 1'b0;
      txn[u] = '0;
      psvc[u] = SVC_NONE;
      part[u] = '0;
      pk[u] = K_NONE;
      ps[u] = '0;
      authq[u] = 1'b0;
      pcnt[u] = 5'd1;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 8; p++) begin
      cfg_write(REG_AUTH_REQ, {4'b0000, auth_tab[p]});
      cfg_write(REG_PART_CNT, cnt_tab[p]);
      authq[1] = auth_tab[p];
      pcnt[1] = cnt_tab[p];
      send_idle = idle_tab[p % 4];
      recv_stall = stall_tab[p % 4];
      if (p == 0) gen_directed();
      target = n_items + 244;
      while (n_items < target) gen_next();
      wait_drained();
    end
    if (errs == 0) $display("gsm_l3_network_session_fsm regression: pass");
    else $display("gsm_l3_network_session_fsm regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("gsm_l3_network_session_fsm regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
